// ===== rtl/pairwise_point_distance_engine_unit_macros.svh =====
// Assertion macros for the pairwise point distance engine.
// Included by the top level, which checks its own logic; depends on nothing else.
`ifndef PAIRWISE_POINT_DISTANCE_ENGINE_UNIT_MACROS_SVH
`define PAIRWISE_POINT_DISTANCE_ENGINE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked check that is switched off while reset is high.
`define PPDE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define PPDE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PPDE_ASSERT(lbl, clk, rst, prop, msg)
`define PPDE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/ppde_pkg.sv =====
// Shared types and constants of the pairwise point distance engine.
// Used by the point cell, the distance unit and the top level; depends on nothing.
package ppde_pkg;

  // Field widths.
  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;
  localparam int SQ_W    = 66;
  localparam int SUM_W   = 67;
  localparam int RAD_W   = 68;
  localparam int ROOT_W  = 34;
  localparam int REM_W   = 36;
  localparam int DIST_W  = 33;
  localparam int EIDX_W  = 5;
  localparam int NIDX_W  = 6;
  localparam int STEP_W  = 6;

  // Last step numbers of the squaring and the root iterations.
  localparam logic [STEP_W-1:0] SQ_LAST   = 6'd32;
  localparam logic [STEP_W-1:0] ROOT_LAST = 6'd33;

  // Distance kinds.
  localparam logic METRIC_MANHATTAN = 1'b0;
  localparam logic METRIC_EUCLID    = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  // Controls of one store cell.
  typedef struct packed {
    logic shift;
    logic wrap;
    logic load;
  } cell_ctl_t;

  // Request to the distance unit.
  typedef struct packed {
    logic start;
    logic metric;
  } dist_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_WAIT,
    S_STORE
  } ctl_state_t;

  typedef enum logic [2:0] {
    D_IDLE,
    D_MAN,
    D_SQUARE,
    D_SUM,
    D_ROOT,
    D_ROUND
  } dist_state_t;

endpackage

// ===== rtl/ppde_cell.sv =====
// One cell of the rotating point store: holds one stored point.
// Depends on ppde_pkg for the point and control types.
module ppde_cell (
  input  logic                clk,
  input  ppde_pkg::cell_ctl_t ctl,
  input  ppde_pkg::point_t    load_pt,
  input  ppde_pkg::point_t    next_pt,
  input  ppde_pkg::point_t    head_pt,
  output ppde_pkg::point_t    pt
);

  // Load a new point, or take the neighbor's point (the head's at the wrap cell).
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pt <= load_pt;
    end else if (ctl.shift) begin
      pt <= ctl.wrap ? head_pt : next_pt;
    end
  end

endmodule

// ===== rtl/ppde_dist.sv =====
// Distance unit: Manhattan sum, or Euclidean by shift-add squaring and a
// bit-pair restoring square root with round to nearest. Depends on ppde_pkg.
module ppde_dist (
  input  logic                               clk,
  input  logic                               rst,
  input  ppde_pkg::dist_req_t                req,
  input  ppde_pkg::point_t                   pa,
  input  ppde_pkg::point_t                   pb,
  output logic                               done,
  output logic [ppde_pkg::DIST_W-1:0]        distance
);

  ppde_pkg::dist_state_t state, state_next;

  logic signed [ppde_pkg::DIFF_W:0] diff_x, diff_y;
  logic [ppde_pkg::DIFF_W-1:0]      abs_x, abs_y;
  logic [ppde_pkg::DIFF_W-1:0]      mpx, mpy;
  logic [ppde_pkg::SQ_W-1:0]        mcx, mcy, accx, accy;
  logic [ppde_pkg::RAD_W-1:0]       rad;
  logic [ppde_pkg::ROOT_W-1:0]      root;
  logic [ppde_pkg::REM_W-1:0]       rem;
  logic [ppde_pkg::REM_W-1:0]       rem_shift, trial;
  logic [ppde_pkg::STEP_W-1:0]      step;
  logic [ppde_pkg::DIFF_W:0]        man_sum;
  logic                             round_up;

  // Absolute coordinate differences, sign extended to avoid overflow.
  always_comb begin
    diff_x = {{2{pa.x[ppde_pkg::COORD_W-1]}}, pa.x} - {{2{pb.x[ppde_pkg::COORD_W-1]}}, pb.x};
    diff_y = {{2{pa.y[ppde_pkg::COORD_W-1]}}, pa.y} - {{2{pb.y[ppde_pkg::COORD_W-1]}}, pb.y};
    abs_x  = diff_x[ppde_pkg::DIFF_W] ? ppde_pkg::DIFF_W'(-diff_x)
                                      : ppde_pkg::DIFF_W'(diff_x);
    abs_y  = diff_y[ppde_pkg::DIFF_W] ? ppde_pkg::DIFF_W'(-diff_y)
                                      : ppde_pkg::DIFF_W'(diff_y);
  end

  // One root step: bring down two radicand bits and try the next root bit.
  always_comb begin
    rem_shift = {rem[ppde_pkg::REM_W-3:0], rad[ppde_pkg::RAD_W-1 -: 2]};
    trial     = {root, 2'b01};
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ppde_pkg::D_IDLE: begin
        if (req.start) begin
          state_next = (req.metric == ppde_pkg::METRIC_EUCLID) ? ppde_pkg::D_SQUARE
                                                               : ppde_pkg::D_MAN;
        end
      end
      ppde_pkg::D_MAN:    state_next = ppde_pkg::D_IDLE;
      ppde_pkg::D_SQUARE: if (step == ppde_pkg::SQ_LAST) state_next = ppde_pkg::D_SUM;
      ppde_pkg::D_SUM:    state_next = ppde_pkg::D_ROOT;
      ppde_pkg::D_ROOT:   if (step == ppde_pkg::ROOT_LAST) state_next = ppde_pkg::D_ROUND;
      ppde_pkg::D_ROUND:  state_next = ppde_pkg::D_IDLE;
      default:            state_next = ppde_pkg::D_IDLE;
    endcase
  end

  // Outputs: the result shows in the cycle of the finishing state.
  always_comb begin
    man_sum  = {1'b0, mpx} + {1'b0, mpy};
    round_up = rem > {{(ppde_pkg::REM_W-ppde_pkg::ROOT_W){1'b0}}, root};
    done     = 1'b0;
    distance = ppde_pkg::DIST_W'(root + ppde_pkg::ROOT_W'(round_up));
    unique case (state)
      ppde_pkg::D_MAN: begin
        done     = 1'b1;
        distance = man_sum[ppde_pkg::DIST_W-1:0];
      end
      ppde_pkg::D_ROUND: done = 1'b1;
      default: done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppde_pkg::D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ppde_pkg::D_IDLE: begin
        mpx  <= abs_x;
        mpy  <= abs_y;
        mcx  <= {{(ppde_pkg::SQ_W-ppde_pkg::DIFF_W){1'b0}}, abs_x};
        mcy  <= {{(ppde_pkg::SQ_W-ppde_pkg::DIFF_W){1'b0}}, abs_y};
        accx <= '0;
        accy <= '0;
        step <= '0;
      end
      ppde_pkg::D_SQUARE: begin
        if (mpx[0]) accx <= accx + mcx;
        if (mpy[0]) accy <= accy + mcy;
        mcx  <= mcx << 1;
        mcy  <= mcy << 1;
        mpx  <= mpx >> 1;
        mpy  <= mpy >> 1;
        step <= step + 1'b1;
      end
      ppde_pkg::D_SUM: begin
        rad  <= {1'b0, ppde_pkg::SUM_W'({1'b0, accx} + {1'b0, accy})};
        root <= '0;
        rem  <= '0;
        step <= '0;
      end
      ppde_pkg::D_ROOT: begin
        if (rem_shift >= trial) begin
          rem  <= rem_shift - trial;
          root <= {root[ppde_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_shift;
          root <= {root[ppde_pkg::ROOT_W-2:0], 1'b0};
        end
        rad  <= rad << 2;
        step <= step + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/pairwise_point_distance_engine_unit.sv =====
// Pairwise point distance engine: one distance for each stored point per item.
// Each distance is computed in turn by the shared distance unit, whose serial squaring
// and root make a Euclidean result take longer than a Manhattan one. busy holds from
// acceptance through the store write, so a new item is taken only once the last is done.
// Synchronous active-high reset empties the store, sets the Manhattan metric; results
// are strobes the receiver cannot stall.
`include "pairwise_point_distance_engine_unit_macros.svh"

module pairwise_point_distance_engine_unit #(
  parameter int MAX_POINTS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic                                 cfg_wdata,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [ppde_pkg::COORD_W-1:0]  x_coord,
  input  logic signed [ppde_pkg::COORD_W-1:0]  y_coord,
  input  logic                                 new_set,
  output logic                                 valid,
  output logic [ppde_pkg::DIST_W-1:0]          distance,
  output logic [ppde_pkg::EIDX_W-1:0]          earlier_index,
  output logic [ppde_pkg::NIDX_W-1:0]          new_index,
  output logic                                 last
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_POINTS);

  ppde_pkg::ctl_state_t state, state_next;

  logic                    metric;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        n_q;
  logic [IDX_W-1:0]        k;
  ppde_pkg::point_t        pt_new;
  ppde_pkg::point_t        cell_pt [MAX_POINTS];
  ppde_pkg::cell_ctl_t     cell_ctl [MAX_POINTS];
  ppde_pkg::dist_req_t     req;
  logic                    dist_done;
  logic [ppde_pkg::DIST_W-1:0] dist_val;
  logic                    accept;
  logic                    shift;
  logic                    is_last;

  assign accept  = start && !busy;
  assign is_last = (k == IDX_W'(n_q - 1'b1));

  // Next state of the item sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ppde_pkg::S_IDLE: begin
        if (start) begin
          state_next = (new_set || count == '0) ? ppde_pkg::S_STORE : ppde_pkg::S_LAUNCH;
        end
      end
      ppde_pkg::S_LAUNCH: state_next = ppde_pkg::S_WAIT;
      ppde_pkg::S_WAIT: begin
        if (dist_done) state_next = is_last ? ppde_pkg::S_STORE : ppde_pkg::S_LAUNCH;
      end
      ppde_pkg::S_STORE: state_next = ppde_pkg::S_IDLE;
      default:           state_next = ppde_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy       = 1'b1;
    req.start  = 1'b0;
    req.metric = metric;
    shift      = 1'b0;
    unique case (state)
      ppde_pkg::S_IDLE:   busy = 1'b0;
      ppde_pkg::S_LAUNCH: req.start = 1'b1;
      ppde_pkg::S_WAIT:   shift = dist_done;
      default:            busy = 1'b1;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ppde_pkg::S_IDLE;
      metric <= ppde_pkg::METRIC_MANHATTAN;
      count  <= '0;
      valid  <= 1'b0;
    end else begin
      state <= state_next;
      valid <= shift;
      if (cfg_we) metric <= cfg_wdata;
      if (state == ppde_pkg::S_STORE) begin
        count <= (n_q == FULL) ? n_q : n_q + 1'b1;
      end
    end
  end

  // Item latch, pair counter and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      pt_new.x <= x_coord;
      pt_new.y <= y_coord;
      n_q      <= new_set ? '0 : count;
      k        <= '0;
    end
    if (shift) begin
      k             <= k + 1'b1;
      distance      <= dist_val;
      earlier_index <= ppde_pkg::EIDX_W'(k);
      new_index     <= ppde_pkg::NIDX_W'(n_q);
      last          <= is_last;
    end
  end

  // Rotating store: the occupied cells turn by one place per result, so the
  // head cell presents the points in store order and the order is back after n turns.
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    ppde_pkg::point_t next_pt;
    if (i == MAX_POINTS - 1) begin : g_tail
      assign next_pt = cell_pt[0];
    end else begin : g_body
      assign next_pt = cell_pt[i + 1];
    end

    assign cell_ctl[i].shift = shift;
    assign cell_ctl[i].wrap  = (CNT_W'(i + 1) == n_q);
    assign cell_ctl[i].load  = (state == ppde_pkg::S_STORE) && (CNT_W'(i) == n_q);

    ppde_cell u_cell (
      .clk     (clk),
      .ctl     (cell_ctl[i]),
      .load_pt (pt_new),
      .next_pt (next_pt),
      .head_pt (cell_pt[0]),
      .pt      (cell_pt[i])
    );
  end

  // Shared distance unit, fed from the head cell.
  ppde_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .pa       (cell_pt[0]),
    .pb       (pt_new),
    .done     (dist_done),
    .distance (dist_val)
  );

  // Results appear only while an item is in work.
  `PPDE_ASSERT(a_valid_busy, clk, rst, valid |-> busy, "result strobe outside an item")
  // Two results never come in adjacent cycles.
  `PPDE_ASSERT(a_valid_gap, clk, rst, valid |=> !valid, "result strobes back to back")
  // An accepted item always makes the block busy.
  `PPDE_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy, "item accepted but not busy")
  // The final result of an item comes with the store write, then the block is idle.
  `PPDE_ASSERT(a_last_done, clk, rst, (valid && last) |=> !busy, "no idle after last result")

endmodule
